### hw/rtl/vertex_dedup_hash_table_unit_macros.svh
// assertion macros used by the vertex dedup hash table back end
`ifndef VERTEX_DEDUP_HASH_TABLE_UNIT_MACROS_SVH
`define VERTEX_DEDUP_HASH_TABLE_UNIT_MACROS_SVH

// condition that must hold at every rising clock edge out of reset
`define VDH_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("vdh assertion failed");

// implication checked at every rising clock edge out of reset
`define VDH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vdh assertion failed");

`endif

### hw/rtl/vdh_pkg.sv
// types, constants and the quantizer function of the vertex dedup hash table
package vdh_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int TABLE_SLOTS_DEF  = 8192;
  localparam int HASH_MAX_W       = 17;
  localparam int IDX_W            = 12;
  localparam int EPOCH_W          = 4;
  localparam int KEY_W            = 179;

  localparam logic [16:0] COORD_SCALE = 17'd100000;
  localparam logic [16:0] NORM_SCALE  = 17'd1000;

  // quantized key words
  typedef struct packed {
    logic [57:0] c;
    logic [56:0] b;
    logic [63:0] a;
  } key_t;

  // item passed from front to back
  typedef struct packed {
    logic                  start;
    key_t                  key;
    logic [HASH_MAX_W-1:0] hash;
  } item_t;

  // one table entry; valid when its epoch matches the current one
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    key_t               key;
    logic [IDX_W-1:0]   idx;
  } entry_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_CHECK,
    B_DONE
  } back_state_t;

  // scale and round half away from zero, saturate to out_w bits signed
  function automatic logic [31:0] quantize(logic [38:0] v, int unsigned frac,
                                           logic [16:0] scale, int unsigned out_w);
    logic        neg;
    logic [38:0] mag;
    logic [55:0] prod;
    logic [55:0] q;
    logic [55:0] lim;
    neg  = v[38];
    mag  = neg ? (~v + 39'd1) : v;
    prod = 56'(mag) * 56'(scale);
    q    = (prod + (56'd1 << (frac - 1))) >> frac;
    lim  = 56'd1 << (out_w - 1);
    if (neg) begin
      if (q > lim) q = lim;
      q = 56'd0 - q;
    end else begin
      if (q > lim - 56'd1) q = lim - 56'd1;
    end
    return q[31:0];
  endfunction

endpackage

### hw/rtl/vdh_front.sv
// front end: quantizes the vertex into a key and hashes it to a home slot
module vdh_front #(
  parameter int TABLE_SLOTS = vdh_pkg::TABLE_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [239:0]   s_tdata,
  input  logic [0:0]     s_tuser,
  output logic           q_valid,
  input  logic           q_ready,
  output vdh_pkg::item_t q_item
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam logic [SLOT_W:0] SLOTS_L = (SLOT_W + 1)'(TABLE_SLOTS);

  logic          v1, v2, adv2, acc;
  logic          st1, st2;
  vdh_pkg::key_t key1, key2, key_in;
  logic [SLOT_W-1:0] fold;
  logic [SLOT_W:0]   fold_x;
  logic [SLOT_W-1:0] home;
  logic [SLOT_W-1:0] hash2;
  logic [31:0] qpx, qpy, qpz, qnx, qny, qnz, qu, qv;

  assign adv2     = !v2 || q_ready;
  assign s_tready = !v1 || adv2;
  assign acc      = s_tvalid && s_tready;

  // quantize all eight coordinates
  always_comb begin
    qpx = vdh_pkg::quantize(s_tdata[38:0], 24, vdh_pkg::COORD_SCALE, 32);
    qpy = vdh_pkg::quantize(s_tdata[77:39], 24, vdh_pkg::COORD_SCALE, 32);
    qpz = vdh_pkg::quantize(s_tdata[116:78], 24, vdh_pkg::COORD_SCALE, 32);
    qnx = vdh_pkg::quantize({{21{s_tdata[134]}}, s_tdata[134:117]}, 16,
                            vdh_pkg::NORM_SCALE, 11);
    qny = vdh_pkg::quantize({{21{s_tdata[152]}}, s_tdata[152:135]}, 16,
                            vdh_pkg::NORM_SCALE, 11);
    qnz = vdh_pkg::quantize({{21{s_tdata[170]}}, s_tdata[170:153]}, 16,
                            vdh_pkg::NORM_SCALE, 11);
    qu  = vdh_pkg::quantize({{7{s_tdata[202]}}, s_tdata[202:171]}, 24,
                            vdh_pkg::COORD_SCALE, 25);
    qv  = vdh_pkg::quantize({{7{s_tdata[234]}}, s_tdata[234:203]}, 24,
                            vdh_pkg::COORD_SCALE, 25);
    key_in.a = {qpy, qpx};
    key_in.b = {qu[24:0], qpz};
    key_in.c = {qv[24:0], qnz[10:0], qny[10:0], qnx[10:0]};
  end

  // xor fold of the key, then one conditional subtract into the slot range
  always_comb begin
    fold = '0;
    for (int j = 0; j < vdh_pkg::KEY_W; j++) begin
      fold[j % SLOT_W] = fold[j % SLOT_W] ^ key1[j];
    end
    fold_x = {1'b0, fold};
    if (fold_x >= SLOTS_L) fold_x = fold_x - SLOTS_L;
    home = fold_x[SLOT_W-1:0];
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (s_tready) v1 <= s_tvalid;
      if (adv2) v2 <= v1;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (acc) begin
      st1  <= s_tuser[0];
      key1 <= key_in;
    end
    if (adv2 && v1) begin
      st2   <= st1;
      key2  <= key1;
      hash2 <= home;
    end
  end

  assign q_valid      = v2;
  assign q_item.start = st2;
  assign q_item.key   = key2;
  assign q_item.hash  = vdh_pkg::HASH_MAX_W'(hash2);

endmodule

### hw/rtl/vdh_queue.sv
// two-entry queue between the front end and the table walker
module vdh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vdh_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output vdh_pkg::item_t out_item
);

  vdh_pkg::item_t slots [2];
  logic [1:0] cnt;
  logic       wr_ptr, rd_ptr, push, pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

endmodule

### hw/rtl/vdh_back.sv
// back end: walks the table by linear probing, inserts new keys, drives results
module vdh_back #(
  parameter int MAX_VERTICES = vdh_pkg::MAX_VERTICES_DEF,
  parameter int TABLE_SLOTS  = vdh_pkg::TABLE_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  vdh_pkg::item_t q_item,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [15:0]    m_tdata,
  output logic [1:0]     m_tuser
);

  `include "vertex_dedup_hash_table_unit_macros.svh"

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  MAX_L     = CNT_W'(MAX_VERTICES);
  localparam logic [vdh_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;

  vdh_pkg::back_state_t state, state_next;
  vdh_pkg::entry_t      mem [TABLE_SLOTS];
  vdh_pkg::entry_t      rdata, wdata;
  vdh_pkg::key_t        key_r;

  logic [SLOT_W-1:0] addr, probes, clr_addr, waddr;
  logic [CNT_W-1:0]  vcount;
  logic [vdh_pkg::EPOCH_W-1:0] epoch;
  logic held, we, rd_en, slot_empty, key_hit, clr_last, pop, out_load;
  logic [vdh_pkg::IDX_W-1:0] res_index;
  logic res_new, res_ovf;

  assign slot_empty = (rdata.epoch != epoch);
  assign key_hit    = !slot_empty && (rdata.key == key_r);
  assign clr_last   = (clr_addr == LAST_SLOT);
  assign pop        = q_valid && q_ready;
  assign out_load   = (state == vdh_pkg::B_DONE) && (!m_tvalid || m_tready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      vdh_pkg::B_CLEAR: if (clr_last) state_next = held ? vdh_pkg::B_READ : vdh_pkg::B_IDLE;
      vdh_pkg::B_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.start && epoch == EPOCH_MAX) ? vdh_pkg::B_CLEAR
                                                             : vdh_pkg::B_READ;
        end
      end
      vdh_pkg::B_READ: state_next = vdh_pkg::B_CHECK;
      vdh_pkg::B_CHECK: begin
        if (slot_empty || key_hit || probes == LAST_SLOT) state_next = vdh_pkg::B_DONE;
        else state_next = vdh_pkg::B_READ;
      end
      vdh_pkg::B_DONE: if (!m_tvalid || m_tready) state_next = vdh_pkg::B_IDLE;
      default: state_next = vdh_pkg::B_IDLE;
    endcase
  end

  // outputs of the walker
  always_comb begin
    q_ready = 1'b0;
    rd_en   = 1'b0;
    we      = 1'b0;
    waddr   = addr;
    wdata.epoch = epoch;
    wdata.key   = key_r;
    wdata.idx   = vdh_pkg::IDX_W'(vcount);
    unique case (state)
      vdh_pkg::B_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_addr;
        wdata.epoch = '0;
      end
      vdh_pkg::B_IDLE:  q_ready = 1'b1;
      vdh_pkg::B_READ:  rd_en = 1'b1;
      vdh_pkg::B_CHECK: we = slot_empty && (vcount < MAX_L);
      vdh_pkg::B_DONE:  ;
      default: ;
    endcase
  end

  // table memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= vdh_pkg::B_CLEAR;
      clr_addr <= '0;
      held     <= 1'b0;
      epoch    <= '0;
      vcount   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == vdh_pkg::B_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
        if (clr_last) epoch <= {{(vdh_pkg::EPOCH_W - 1){1'b0}}, 1'b1};
      end
      if (pop) begin
        held <= 1'b1;
        if (q_item.start) begin
          vcount <= '0;
          if (epoch != EPOCH_MAX) epoch <= epoch + 1'b1;
        end
      end
      if (state == vdh_pkg::B_CHECK && we) vcount <= vcount + 1'b1;
      if (out_load) held <= 1'b0;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // item payload and probe walk
  always_ff @(posedge clk) begin
    if (pop) begin
      key_r  <= q_item.key;
      addr   <= q_item.hash[SLOT_W-1:0];
      probes <= '0;
    end
    if (state == vdh_pkg::B_CHECK) begin
      addr    <= (addr == LAST_SLOT) ? '0 : addr + 1'b1;
      probes  <= probes + 1'b1;
      res_new <= 1'b0;
      res_ovf <= 1'b0;
      res_index <= '0;
      if (key_hit) begin
        res_index <= rdata.idx;
      end else if (slot_empty) begin
        if (vcount < MAX_L) begin
          res_new   <= 1'b1;
          res_index <= vdh_pkg::IDX_W'(vcount);
        end else begin
          res_ovf <= 1'b1;
        end
      end else if (probes == LAST_SLOT) begin
        res_ovf <= 1'b1;
      end
    end
    if (out_load) begin
      m_tdata <= {{(16 - vdh_pkg::IDX_W){1'b0}}, res_index};
      m_tuser <= {res_ovf, res_new};
    end
  end

  `VDH_ASSERT_ALWAYS(a_count_bound, vcount <= MAX_L)
  `VDH_ASSERT_IMPL(a_write_state, we, state == vdh_pkg::B_CHECK || state == vdh_pkg::B_CLEAR)
  `VDH_ASSERT_IMPL(a_flags_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]))
  `VDH_ASSERT_IMPL(a_check_after_read, state == vdh_pkg::B_CHECK, $past(state) == vdh_pkg::B_READ)

endmodule

### hw/rtl/vertex_dedup_hash_table_unit.sv
// Vertex welding unit: each item is one vertex, quantized into a key and looked up
// in an open-addressed table with linear probing. A new key gets the next dense
// index with is_new set; a repeated key returns its stored index; a new key that
// finds the vertex limit or table full gives index 0 with overflow set. Flow: the
// front end is a two-stage quantize/hash pipeline; the table walker then dequeues
// an item, does each probe as a registered memory read followed by a compare, and
// hands over the result, one probe being the usual case at moderate load. After
// reset, and on every 15th start_mesh, the walker sweeps the whole table to retire
// stale entries; other start_mesh items only bump an epoch mark.
module vertex_dedup_hash_table_unit #(
  parameter int MAX_VERTICES = vdh_pkg::MAX_VERTICES_DEF,
  parameter int TABLE_SLOTS  = vdh_pkg::TABLE_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, zero pad
  input  logic [239:0] s_tdata,
  // start_mesh
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_index, zero pad
  output logic [15:0]  m_tdata,
  // is_new, overflow
  output logic [1:0]   m_tuser
);

  logic           f_valid, f_ready, b_valid, b_ready;
  vdh_pkg::item_t f_item, b_item;

  // quantize and hash
  vdh_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  // decoupling queue
  vdh_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
  );

  // table walk and result
  vdh_back #(.MAX_VERTICES(MAX_VERTICES), .TABLE_SLOTS(TABLE_SLOTS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule

### verif/tb.sv
// self-checking testbench for the vertex dedup hash table unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_VERT    = 4096;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_ITEMS  = 600;

  typedef struct {
    bit        start;
    bit [38:0] px, py, pz;
    bit [17:0] nx, ny, nz;
    bit [31:0] u, v;
  } vertex_t;

  typedef struct {
    bit [11:0] idx;
    bit        is_new;
    bit        ovf;
  } weld_t;

  typedef struct {
    vertex_t vtx;
    bit      typed;
    weld_t   res;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [239:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;
  logic [1:0]   m_tuser;

  vertex_dedup_hash_table_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // clock, period 12 ns
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // welded key store of the current mesh
  int unsigned key_to_index[bit [178:0]];
  int unsigned vert_count = 0;
  weld_t       pending_welds[$];
  row_t        rows[$];
  int          errors = 0;
  int          n_in = 0, n_out = 0, n_new = 0, n_ovf = 0, n_mesh = 0;
  bit          no_idle = 0;
  int unsigned cycles = 0;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_welds.size());
      $display("[vertex_dedup_hash_table_unit] ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", n_out, what, got, want);
    errors++;
  endtask

  // append one row to the directed table
  task automatic add_row(input vertex_t v, input bit typed, input weld_t res);
    row_t r;
    r.vtx   = v;
    r.typed = typed;
    r.res   = res;
    rows.insert(rows.size(), r);
  endtask

  // scale, round half away from zero, saturate to ow bits signed
  function automatic bit [63:0] quant(bit [63:0] raw, int w, int frac, bit [63:0] scale,
                                      int ow);
    bit [63:0] v, mag, q, lim;
    bit        neg;
    v   = raw & ((64'd1 << w) - 1);
    neg = v[w-1];
    mag = neg ? ((64'd1 << w) - v) : v;
    q   = (mag * scale + (64'd1 << (frac - 1))) >> frac;
    lim = 64'd1 << (ow - 1);
    if (neg) begin
      if (q > lim) q = lim;
      q = 64'd0 - q;
    end else if (q > lim - 1) begin
      q = lim - 1;
    end
    return q & ((64'd1 << ow) - 1);
  endfunction

  // dedup prediction for one accepted vertex
  function automatic weld_t weld(vertex_t x);
    bit [178:0] key;
    weld_t      r;
    if (x.start) begin
      key_to_index.delete();
      vert_count = 0;
    end
    key = {32'(quant(x.px, 39, 24, 100000, 32)), 32'(quant(x.py, 39, 24, 100000, 32)),
           32'(quant(x.pz, 39, 24, 100000, 32)), 11'(quant(x.nx, 18, 16, 1000, 11)),
           11'(quant(x.ny, 18, 16, 1000, 11)), 11'(quant(x.nz, 18, 16, 1000, 11)),
           25'(quant(x.u, 32, 24, 100000, 25)), 25'(quant(x.v, 32, 24, 100000, 25))};
    r = '{0, 0, 0};
    if (key_to_index.exists(key)) begin
      r.idx = key_to_index[key][11:0];
    end else if (vert_count >= MAX_VERT) begin
      r.ovf = 1;
    end else begin
      key_to_index[key] = vert_count;
      r.idx    = vert_count[11:0];
      r.is_new = 1;
      vert_count++;
    end
    return r;
  endfunction

  // offer one vertex, wait for acceptance, queue its expected result
  task automatic send_vertex(input vertex_t x, input bit typed, input weld_t res);
    int    gap;
    weld_t w;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, x.v, x.u, x.nz, x.ny, x.nx, x.pz, x.py, x.px};
    s_tuser  <= x.start;
    do @(posedge clk); while (!s_tready);
    w = weld(x);
    pending_welds.insert(pending_welds.size(), typed ? res : w);
    n_in++;
    if (x.start) n_mesh++;
  endtask

  // result side: random stalls, one long hold-off, field checks
  initial begin
    int    stall;
    weld_t e;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (n_out == 40) stall = 400;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_welds.size() == 0) begin
        $display("unexpected result index %0d", m_tdata[11:0]);
        errors++;
      end else begin
        e = pending_welds.pop_front();
        if (m_tdata[11:0] != e.idx) report("out_index", m_tdata[11:0], e.idx);
        if (m_tuser[0] != e.is_new) report("is_new", m_tuser[0], e.is_new);
        if (m_tuser[1] != e.ovf) report("overflow", m_tuser[1], e.ovf);
        if (m_tdata[15:12] != 4'd0) report("tdata pad", m_tdata[15:12], 0);
        if (e.is_new) n_new++;
        if (e.ovf) n_ovf++;
      end
      n_out++;
    end
  end

  function automatic vertex_t rand_vertex(bit noise);
    vertex_t x;
    x.start = 0;
    x.px = 39'({$urandom, $urandom});
    x.py = 39'({$urandom, $urandom});
    x.pz = 39'({$urandom, $urandom});
    if (noise) begin
      x.nx = 18'($urandom); x.ny = 18'($urandom); x.nz = 18'($urandom);
    end else begin
      x.nx = 18'($urandom_range(0, 131072) - 65536);
      x.ny = 18'($urandom_range(0, 131072) - 65536);
      x.nz = 18'($urandom_range(0, 131072) - 65536);
    end
    x.u = $urandom;
    x.v = $urandom;
    return x;
  endfunction

  // stimulus
  initial begin
    vertex_t z, a, b, x;
    vertex_t mesh_pool[$];
    weld_t   none;
    int      left;
    none = '{0, 0, 0};
    z = '{0, 0, 0, 0, 0, 0, 0, 0, 0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table: zero key, extremes, saturation, sign-only rounding, clear
    a = z; a.px = 39'h3F_FFFF_FFFF; a.py = 39'h40_0000_0000; a.pz = 39'h3F_FFFF_FFFF;
    b = z; b.nx = 18'h1FFFF; b.ny = 18'h20000; b.nz = 18'h10000;
    x = z; x.start = 1;
    add_row(x, 1, '{0, 1, 0});
    add_row(z, 1, '{0, 0, 0});
    add_row(a, 1, '{1, 1, 0});
    add_row(b, 1, '{2, 1, 0});
    x = z; x.nx = 18'h10000; x.ny = 18'h30000; x.nz = 18'h30000;
    add_row(x, 1, '{3, 1, 0});
    x = z; x.u = 32'h7FFF_FFFF; x.v = 32'h8000_0000;
    add_row(x, 1, '{4, 1, 0});
    x = z; x.px = 39'd1;
    add_row(x, 1, '{0, 0, 0});
    x = z; x.px = 39'h7F_FFFF_FFFF; x.nz = 18'h3FFFF;
    add_row(x, 1, '{0, 0, 0});
    add_row(a, 1, '{1, 0, 0});
    x = z; x.px = 39'd84; x.u = 32'd84; x.nx = 18'd33;
    add_row(x, 0, none);
    x = z; x.px = 39'h7F_FFFF_FFAC; x.v = 32'hFFFF_FFAC; x.ny = 18'h3FFDF;
    add_row(x, 0, none);
    x = a; x.start = 1;
    add_row(x, 1, '{0, 1, 0});
    add_row(z, 1, '{1, 1, 0});
    add_row(b, 1, '{2, 1, 0});
    foreach (rows[i]) send_vertex(rows[i].vtx, rows[i].typed, rows[i].res);

    // random meshes: new random vertices mixed with repeats and near-repeats of earlier ones
    left = 0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ((i / 100) % 3 == 2) no_idle = 1;
      else no_idle = 0;
      if (left == 0) begin
        left = $urandom_range(1, 60);
        mesh_pool.delete();
      end
      if (mesh_pool.size() > 0 && $urandom_range(0, 9) < 5) begin
        x = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
        if ($urandom_range(0, 3) == 0) x.px ^= 39'($urandom_range(0, 15));
        if ($urandom_range(0, 5) == 0) x.nz ^= 18'($urandom_range(0, 7));
      end else begin
        x = rand_vertex($urandom_range(0, 9) == 0);
      end
      x.start = (mesh_pool.size() == 0);
      mesh_pool.insert(mesh_pool.size(), x);
      send_vertex(x, 0, none);
      left--;
    end

    // fill one mesh past the vertex limit, then repeats and more new keys
    no_idle = 0;
    for (int i = 0; i <= MAX_VERT; i++) begin
      x = z;
      x.start = (i == 0);
      x.px = 39'(i) << 20;
      if (i == MAX_VERT) send_vertex(x, 1, '{0, 0, 1});
      else send_vertex(x, 0, none);
    end
    x = z; x.px = 39'd7 << 20;
    send_vertex(x, 1, '{7, 0, 0});
    x = z; x.py = 39'd5 << 20;
    send_vertex(x, 1, '{0, 0, 1});
    x = z; x.px = 39'd4095 << 20;
    send_vertex(x, 1, '{4095, 0, 0});
    s_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending_welds.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("%0d vertices in %0d meshes, %0d results: %0d new, %0d overflow",
             n_in, n_mesh, n_out, n_new, n_ovf);
    $display("%0d mismatches", errors);
    if (errors == 0) begin
      $display("[vertex_dedup_hash_table_unit] OK");
    end else begin
      $display("[vertex_dedup_hash_table_unit] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/vdh_pkg.sv
hw/rtl/vdh_front.sv
hw/rtl/vdh_queue.sv
hw/rtl/vdh_back.sv
hw/rtl/vertex_dedup_hash_table_unit.sv
verif/tb.sv
